### rtl/core/cfws_pkg.sv
// Shared types and constants for the circular FIFO with search.
`timescale 1ns / 1ps

package cfws_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned CapW     = 5;
  localparam int unsigned CapReset = 16;

  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_SRCH = 2'd2,
    REQ_NOP  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_RSVD      = 2'd3
  } status_e;

  localparam logic signed [WordW-1:0] UnderflowWord = '1;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture the incoming request
    logic srch_step;  // one search step: compare last read, fetch next
    logic commit;     // update the ring and load the output register
  } cfws_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic srch_last;  // the entry under compare is the tail
    logic out_free;   // output register can take a word this cycle
  } cfws_stat_t;

endpackage

### rtl/core/cfws_ctrl.sv
// Controller state machine for the circular FIFO with search.
`timescale 1ns / 1ps

module cfws_ctrl import cfws_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] req_type_i,
  output logic       in_stall_o,
  input  cfws_stat_t stat_i,
  output cfws_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o.load      = accept;
    cmd_o.srch_step = (state_q == S_SRCH);
    cmd_o.commit    = (state_q == S_RESP) && stat_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((req_e'(req_type_i) == REQ_SRCH) && !stat_i.empty) begin
            state_d = S_SRCH;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SRCH: begin
        if (stat_i.srch_last) state_d = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/cfws_dpath.sv
// Datapath: ring memory, pointers, search walker and output register.
`timescale 1ns / 1ps

module cfws_dpath import cfws_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CapW-1:0]         cfg_wdata_i,
  input  logic [1:0]              req_type_i,
  input  logic signed [WordW-1:0] value_in_i,
  input  cfws_cmd_t               cmd_i,
  output cfws_stat_t              stat_o,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic [1:0]              status_o,
  output logic signed [WordW-1:0] value_out_o,
  output logic                    found_o
);

  localparam int unsigned IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned CapRst = (DEPTH < CapReset) ? DEPTH : CapReset;

  logic signed [WordW-1:0] mem_q [DEPTH];
  logic signed [WordW-1:0] rd_data_q;
  logic [IW-1:0]           rd_addr;

  logic [CW-1:0] cap_q, cap_d;
  logic [IW-1:0] head_q, tail_q, srch_idx_q;
  logic          empty_q;
  logic          last_q;
  req_e          req_q;
  logic signed [WordW-1:0] val_q;
  logic          found_q;

  logic                    out_valid_q;
  status_e                 status_q;
  logic signed [WordW-1:0] value_out_q;
  logic                    found_out_q;

  logic [IW-1:0] head_nxt, tail_nxt, srch_nxt;
  logic          full;

  function automatic logic [IW-1:0] step_idx(input logic [IW-1:0] idx,
                                             input logic [CW-1:0] cap);
    logic [CW-1:0] ip1;
    ip1 = CW'(idx) + CW'(1);
    return (ip1 >= cap) ? '0 : ip1[IW-1:0];
  endfunction

  assign head_nxt = step_idx(head_q, cap_q);
  assign tail_nxt = step_idx(tail_q, cap_q);
  assign srch_nxt = step_idx(srch_idx_q, cap_q);
  assign full     = (tail_nxt == head_q);

  // Out-of-range capacity folds into 1..DEPTH
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cap_d = CW'(1);
    end else if (32'(cfg_wdata_i) > 32'(DEPTH)) begin
      cap_d = CW'(DEPTH);
    end else begin
      cap_d = CW'(cfg_wdata_i);
    end
  end

  assign rd_addr = cmd_i.srch_step ? srch_idx_q : head_q;

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr];
    if (cmd_i.commit && (req_q == REQ_ENQ)) begin
      if (empty_q) begin
        mem_q[0] <= val_q;
      end else if (!full) begin
        mem_q[tail_nxt] <= val_q;
      end
    end
  end

  // Request capture and search walker
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q      <= req_e'(req_type_i);
      val_q      <= value_in_i;
      found_q    <= 1'b0;
      srch_idx_q <= head_nxt;
      last_q     <= (head_q == tail_q);
    end else if (cmd_i.srch_step) begin
      if (rd_data_q == val_q) found_q <= 1'b1;
      if (!last_q) begin
        srch_idx_q <= srch_nxt;
        last_q     <= (srch_idx_q == tail_q);
      end
    end
  end

  // Pointers and capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CW'(CapRst);
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else if (cfg_we_i) begin
      cap_q   <= cap_d;
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else if (cmd_i.commit) begin
      case (req_q)
        REQ_ENQ: begin
          if (empty_q) begin
            head_q  <= '0;
            tail_q  <= '0;
            empty_q <= 1'b0;
          end else if (!full) begin
            tail_q <= tail_nxt;
          end
        end
        REQ_DEQ: begin
          if (!empty_q) begin
            if (head_q == tail_q) begin
              head_q  <= '0;
              tail_q  <= '0;
              empty_q <= 1'b1;
            end else begin
              head_q <= head_nxt;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q    <= ST_OK;
      value_out_q <= '0;
      found_out_q <= 1'b0;
      case (req_q)
        REQ_ENQ: begin
          if (!empty_q && full) status_q <= ST_OVERFLOW;
        end
        REQ_DEQ: begin
          if (empty_q) begin
            status_q    <= ST_UNDERFLOW;
            value_out_q <= UnderflowWord;
          end else begin
            value_out_q <= rd_data_q;
          end
        end
        REQ_SRCH: found_out_q <= found_q;
        default: ;
      endcase
    end
  end

  always_comb begin
    stat_o.empty     = empty_q;
    stat_o.srch_last = last_q;
    stat_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_out_o = value_out_q;
  assign found_o     = found_out_q;

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (head_q == '0) && (tail_q == '0))
    else $error("empty queue with nonzero pointers");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW'(head_q) < cap_q) && (CW'(tail_q) < cap_q))
    else $error("pointer beyond capacity");

  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed result not presented");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_i.commit)
    else $error("output word overwritten while stalled");

endmodule

### rtl/core/circular_fifo_with_search.sv
// Top level of the circular FIFO with search: controller plus datapath.
`timescale 1ns / 1ps
// Ring-buffer FIFO of signed 32-bit words with an in-place search.
// Input channel: in_valid_i / in_stall_o carry one request word
//   (req_type_i: 0 enqueue, 1 dequeue, 2 search, 3 no-op; value_in_i).
// Output channel: out_valid_o / out_stall_i carry exactly one result word
//   per request (status_o, value_out_o, found_o), in request order.
// Config: cfg_we_i writes the capacity (0 acts as 1, above DEPTH acts as
//   DEPTH) and empties the queue; write only while the block is idle.
// Sequence: one request is in flight at a time. Enqueue, dequeue, no-op
//   and a search of an empty queue go from accept to the response state. A
//   search on a non-empty queue first walks the ring memory one entry per
//   cycle, head to tail, through its single read port, then goes to the
//   response state; there the result is registered once the output is free.
// Accept: the next request is accepted the cycle after the result is
//   registered.
// Reset: capacity = min(16, DEPTH), queue empty, no result pending. The
//   ring memory is not cleared; entries are only read after being written.
// Stall: a finished result sits in the output register until taken; the
//   next request is accepted meanwhile, and its result waits, with the
//   controller in the response state, until the output register frees.

module circular_fifo_with_search import cfws_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CapW-1:0]         cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              req_type_i,
  input  logic signed [WordW-1:0] value_in_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic signed [WordW-1:0] value_out_o,
  output logic                    found_o
);

  cfws_cmd_t  cmd;
  cfws_stat_t stat;

  cfws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cfws_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_type_i  (req_type_i),
    .value_in_i  (value_in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .value_out_o (value_out_o),
    .found_o     (found_o)
  );

endmodule

### verif/cfws_checker.sv
// Result checker for the circular FIFO with search: predicts each request and compares.
`timescale 1ns / 1ps

module cfws_checker import cfws_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CapW-1:0]         cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [1:0]              req_type_i,
  input  logic signed [WordW-1:0] value_in_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [1:0]              status_i,
  input  logic signed [WordW-1:0] value_out_i,
  input  logic                    found_i,
  output int                      pending_o,
  output int                      fail_count_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);

  typedef struct packed {
    status_e                 status;
    logic signed [WordW-1:0] word;
    logic                    found;
  } fifo_result_t;

  // Predicted ring state
  logic [WordW-1:0] ring_q [DEPTH];
  logic [IdxW-1:0]  head_q;
  logic [IdxW-1:0]  tail_q;
  logic             empty_q;
  logic [CapW-1:0]  cap_q;

  fifo_result_t expected_results [$];

  // Capacity actually in use: 0 acts as 1, above DEPTH acts as DEPTH.
  function automatic int unsigned ring_span();
    if (cap_q == '0) return 1;
    if (cap_q > DEPTH) return DEPTH;
    return cap_q;
  endfunction

  function automatic logic [IdxW-1:0] ring_next(logic [IdxW-1:0] idx);
    int unsigned n;
    n = idx + 1;
    return (n >= ring_span()) ? '0 : IdxW'(n);
  endfunction

  function automatic fifo_result_t fifo_apply(req_e req, logic [WordW-1:0] word);
    fifo_result_t res;
    logic [IdxW-1:0] idx;
    res.status = ST_OK;
    res.word   = '0;
    res.found  = 1'b0;
    case (req)
      REQ_ENQ: begin
        if (empty_q) begin
          head_q    = '0;
          tail_q    = '0;
          ring_q[0] = word;
          empty_q   = 1'b0;
        end else if (ring_next(tail_q) == head_q) begin
          res.status = ST_OVERFLOW;
        end else begin
          tail_q         = ring_next(tail_q);
          ring_q[tail_q] = word;
        end
      end
      REQ_DEQ: begin
        if (empty_q) begin
          res.status = ST_UNDERFLOW;
          res.word   = UnderflowWord;
        end else begin
          res.word = ring_q[head_q];
          if (head_q == tail_q) begin
            head_q  = '0;
            tail_q  = '0;
            empty_q = 1'b1;
          end else begin
            head_q = ring_next(head_q);
          end
        end
      end
      REQ_SRCH: begin
        if (!empty_q) begin
          idx = head_q;
          for (int s = 0; s < DEPTH; s++) begin
            if (ring_q[idx] == word) res.found = 1'b1;
            if (idx == tail_q) break;
            idx = ring_next(idx);
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report(string field, logic signed [WordW-1:0] want,
                        logic signed [WordW-1:0] got);
    fail_count_o++;
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fifo_result_t seen;
    fifo_result_t want;
    if (!rst_ni) begin
      head_q  = '0;
      tail_q  = '0;
      empty_q = 1'b1;
      cap_q   = CapW'(CapReset);
      expected_results.delete();
    end else begin
      // Drain side first: a word leaving now always belongs to an earlier request.
      if (out_valid_i && !out_stall_i) begin
        seen.status = status_e'(status_i);
        seen.word   = value_out_i;
        seen.found  = found_i;
        if (expected_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected word: status %0d value %0d found %0d",
                   $time, status_i, value_out_i, found_i);
        end else begin
          want = expected_results.pop_front();
          if (seen.status != want.status)
            report("status", WordW'(want.status), WordW'(seen.status));
          if (seen.word != want.word) report("value_out", want.word, seen.word);
          if (seen.found != want.found)
            report("found", WordW'(want.found), WordW'(seen.found));
        end
      end
      if (cfg_we_i) begin
        cap_q   = cfg_wdata_i;
        head_q  = '0;
        tail_q  = '0;
        empty_q = 1'b1;
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(fifo_apply(req_e'(req_type_i), value_in_i));
    end
    pending_o = expected_results.size();
  end

endmodule

### verif/tb.sv
// Testbench top for the circular FIFO with search: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb import cfws_pkg::*; ();

  localparam int unsigned DEPTH = 16;
  localparam int CycleLimit     = 1_000_000; // far above the slowest legal run
  localparam int LongHold       = 300;       // receiver hold-off, fills the block
  localparam int PhaseWords     = 250;       // random words per capacity setting
  localparam int HistDepth      = 16;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CapW-1:0]         cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              req_type;
  logic signed [WordW-1:0] value_in;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              status;
  logic signed [WordW-1:0] value_out;
  logic                    found;

  int pending;
  int fail_count;
  int cycles = 0;

  // Shared between the sender and the receiver; both written only at negedge
  // with nonblocking updates, so each side sees a stable value.
  logic quiet;    // no gaps and no stalls on either side
  int   hold_seq; // bump to request one long receiver hold-off

  // Recently enqueued words, so searches hit and enqueues repeat values.
  logic [WordW-1:0] recent_words [HistDepth];
  int               recent_ptr;

  always #2 clk = ~clk;

  circular_fifo_with_search #(.DEPTH(DEPTH)) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .req_type_i  (req_type),
    .value_in_i  (value_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .value_out_o (value_out),
    .found_o     (found)
  );

  cfws_checker #(.DEPTH(DEPTH)) u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .req_type_i   (req_type),
    .value_in_i   (value_in),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .status_i     (status),
    .value_out_i  (value_out),
    .found_i      (found),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Watchdog: cycle counter, ends the run if the flow ever hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random stall runs, mostly short, a few long; a long hold-off
  // whenever the sender bumps hold_seq; none at all while quiet.
  initial begin
    int seen_hold;
    int stall_left;
    int r;
    seen_hold  = 0;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != seen_hold) begin
        seen_hold = hold_seq;
        out_stall <= 1'b1;
        repeat (LongHold) @(negedge clk);
        out_stall <= 1'b0;
      end else if (quiet) begin
        stall_left = 0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall <= 1'b0;
        end else begin
          stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                    : $urandom_range(9, 39);
          out_stall <= 1'b1;
        end
      end
    end
  end

  // Offer one request word, hold it until taken, then maybe leave a gap.
  // Entered and left at a falling edge.
  task automatic send_word(req_e req, logic [WordW-1:0] word);
    int r;
    int gap;
    in_valid <= 1'b1;
    req_type <= req;
    value_in <= word;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (req == REQ_ENQ) begin
      recent_words[recent_ptr] = word;
      recent_ptr = (recent_ptr + 1) % HistDepth;
    end
    gap = 0;
    if (!quiet) begin
      r = $urandom_range(0, 99);
      if (r >= 92) gap = $urandom_range(8, 40);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Sender pauses until every predicted word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Capacity write; only called with the block idle. Empties the queue.
  task automatic write_capacity(logic [CapW-1:0] cap);
    cfg_wdata <= cap;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Word mix: mostly random, some from history (more so for searches), some
  // small values for duplicates, some extremes.
  function automatic logic [WordW-1:0] pick_word(bit from_history);
    int r;
    r = $urandom_range(0, 99);
    if (from_history && r < 50) return recent_words[$urandom_range(0, HistDepth - 1)];
    if (r < 60) return $urandom();
    if (r < 75) return recent_words[$urandom_range(0, HistDepth - 1)];
    if (r < 90) return $urandom_range(0, 1) ? $urandom_range(0, 7) : -$urandom_range(1, 8);
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Random traffic in bursts that lean toward filling or toward draining,
  // so the ring keeps hitting full, empty and the wrap point.
  task automatic random_phase(int count);
    int   burst;
    int   enq_bias;
    int   r;
    req_e req;
    burst    = 0;
    enq_bias = 50;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst    = $urandom_range(1, 40);
        enq_bias = $urandom_range(0, 1) ? 70 : 25;
      end
      burst--;
      r = $urandom_range(0, 99);
      if (r < 4) req = REQ_NOP;
      else if (r < 20) req = REQ_SRCH;
      else if ($urandom_range(0, 99) < enq_bias) req = REQ_ENQ;
      else req = REQ_DEQ;
      send_word(req, pick_word(req == REQ_SRCH));
    end
  endtask

  initial begin
    logic [CapW-1:0] phase_caps [8];
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    req_type   = REQ_NOP;
    value_in   = '0;
    quiet      = 1'b0;
    hold_seq   = 0;
    recent_ptr = 0;
    for (int i = 0; i < HistDepth; i++) recent_words[i] = '0;
    // Extremes of the register among the settings: 0 acts as 1, 31 as DEPTH.
    phase_caps = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd17, 5'd8, 5'd2, 5'd0};
    phase_caps[7] = CapW'($urandom_range(0, 31));

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset capacity: underflow, empty search, no-op, extreme
    // words, search hits at head and tail, a miss, drain to underflow.
    send_word(REQ_DEQ,  $urandom());
    send_word(REQ_SRCH, 32'h1234_5678);
    send_word(REQ_NOP,  '1);
    send_word(REQ_ENQ,  32'h8000_0000);
    send_word(REQ_ENQ,  32'h7FFF_FFFF);
    send_word(REQ_SRCH, 32'h7FFF_FFFF);
    send_word(REQ_SRCH, 32'h8000_0000);
    send_word(REQ_SRCH, '0);
    send_word(REQ_DEQ,  $urandom());
    send_word(REQ_DEQ,  $urandom());
    send_word(REQ_DEQ,  $urandom());
    wait_drained();

    // Capacity 0 behaves as a single entry: second enqueue overflows.
    write_capacity(5'd0);
    send_word(REQ_ENQ,  '1);
    send_word(REQ_ENQ,  32'd5);
    send_word(REQ_SRCH, '1);
    send_word(REQ_DEQ,  $urandom());
    wait_drained();

    // Capacity 2: overflow, then tail wraps to entry 0 and search walks
    // across the wrap.
    write_capacity(5'd2);
    send_word(REQ_ENQ,  32'd1);
    send_word(REQ_ENQ,  32'd2);
    send_word(REQ_ENQ,  32'd3);
    send_word(REQ_DEQ,  $urandom());
    send_word(REQ_ENQ,  32'd4);
    send_word(REQ_SRCH, 32'd4);
    send_word(REQ_SRCH, 32'd1);
    send_word(REQ_DEQ,  $urandom());
    send_word(REQ_DEQ,  $urandom());
    send_word(REQ_NOP,  $urandom());
    wait_drained();

    // Random phases, one per capacity setting, fully drained in between.
    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      quiet <= (p == 5);
      if (p == 2) begin
        // Receiver blocks for a long stretch while requests keep coming,
        // so the block fills and pushes back on its input.
        hold_seq <= hold_seq + 1;
      end
      @(negedge clk);
      random_phase(PhaseWords);
      wait_drained();
    end
    quiet <= 1'b0;

    // Let any stray extra word show up before the verdict.
    repeat (2 * DEPTH + 8) @(negedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
